/* rtl/tlvf_pkg.sv */
// Shared types and constants for the text line view filter.
// No dependencies; tlvf_line_ctl, tlvf_drain and the top import this package.
package tlvf_pkg;

  localparam int NUMBER_DIGITS = 6;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_I      = 8'd73;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CTRL_LIMIT   = 8'd32;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_NONBLANK  = 3'd0,
    CFG_NUMBER_ALL       = 3'd1,
    CFG_SQUEEZE_BLANK    = 3'd2,
    CFG_SHOW_TABS        = 3'd3,
    CFG_SHOW_ENDS        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } tlvf_cfg_idx_e;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_tabs;
    logic show_ends;
    logic show_nonprinting;
  } tlvf_cfg_t;

  // Expansion of one byte, apart from the number digits.
  typedef struct packed {
    logic       num_v;      // number digits and tab go out first
    logic       mark_v;     // caret or dollar before the char
    logic [7:0] mark_byte;
    logic [7:0] char_byte;
  } tlvf_item_t;

endpackage

/* rtl/tlvf_in_if.sv */
// Input stream channel: one text byte plus new-file flag per beat.
// Depends on nothing.
interface tlvf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

/* rtl/tlvf_out_if.sv */
// Output stream channel: one output byte plus last flag per beat.
// Depends on nothing.
interface tlvf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

/* rtl/tlvf_line_ctl.sv */
// Line state (newline flag, blank run, BCD line counter) and byte expansion.
// Depends on tlvf_pkg.
module tlvf_line_ctl import tlvf_pkg::*; #(
  parameter int NumDigits = NUMBER_DIGITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     file_start_i,
  input  tlvf_cfg_t                cfg_i,
  output logic                     load_o,
  output tlvf_item_t               item_o,
  output logic [NumDigits-1:0][7:0] digit_chars_o
);

  localparam int BcdW = 4 * NumDigits;

  logic            prev_q, prev_d;
  logic [1:0]      blank_q, blank_d;
  logic [BcdW-1:0] bcd_q, bcd_d;

  logic            prev_c;
  logic [1:0]      blank_c;
  logic [BcdW-1:0] bcd_c, bcd_inc;
  logic            squeeze, suppress, full;

  always_comb begin
    logic       zero_above;
    logic       carry;
    logic [3:0] d;
    logic [7:0] ch;

    // new file restarts the line state before the byte is handled
    prev_c  = file_start_i ? 1'b1 : prev_q;
    blank_c = file_start_i ? 2'd0 : blank_q;
    bcd_c   = file_start_i ? BcdW'(1) : bcd_q;

    squeeze  = cfg_i.squeeze_blank && (data_byte_i == CH_NL) && prev_c;
    suppress = squeeze && (blank_c != 2'd0);
    blank_d  = squeeze ? ((blank_c == 2'd0) ? 2'd1 : 2'd2) : 2'd0;

    item_o.num_v = prev_c && ((cfg_i.number_nonblank && (data_byte_i != CH_NL)) ||
                              (cfg_i.number_all && !cfg_i.number_nonblank));

    // digits, most significant first, leading zeros as spaces
    zero_above = 1'b1;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      d = bcd_c[4*i +: 4];
      if (d != 4'd0 || i == 0) zero_above = 1'b0;
      digit_chars_o[NumDigits-1-i] = zero_above ? CH_SPACE : (CH_ZERO + {4'd0, d});
    end

    // saturating BCD increment
    full  = 1'b1;
    carry = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      d = bcd_c[4*i +: 4];
      if (d != 4'd9) full = 1'b0;
      if (carry) begin
        bcd_inc[4*i +: 4] = (d == 4'd9) ? 4'd0 : d + 4'd1;
        carry = (d == 4'd9);
      end else begin
        bcd_inc[4*i +: 4] = d;
      end
    end

    ch               = data_byte_i;
    item_o.mark_v    = 1'b0;
    item_o.mark_byte = CH_CARET;
    if (cfg_i.show_tabs && ch == CH_TAB) begin
      item_o.mark_v = 1'b1;
      ch            = CH_I;
    end else if (cfg_i.show_nonprinting && ch < CTRL_LIMIT && ch != CH_TAB && ch != CH_NL) begin
      item_o.mark_v = 1'b1;
      ch            = ch + CARET_OFFSET;
    end else if (cfg_i.show_ends && ch == CH_NL) begin
      item_o.mark_v    = 1'b1;
      item_o.mark_byte = CH_DOLLAR;
    end
    item_o.char_byte = ch;

    prev_d = (data_byte_i == CH_NL);
    bcd_d  = (item_o.num_v && !full) ? bcd_inc : bcd_c;
  end

  assign load_o = accept_i && !suppress;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      blank_q <= 2'd0;
      bcd_q   <= BcdW'(1);
    end else if (accept_i) begin
      blank_q <= blank_d;
      if (!suppress) begin
        prev_q <= prev_d;
        bcd_q  <= bcd_d;
      end
    end
  end

`ifndef SYNTHESIS
  logic bcd_ok;
  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] > 4'd9) bcd_ok = 1'b0;
    end
  end

  a_blank_sat: assert property (@(posedge clk_i) disable iff (!rst_ni) blank_q != 2'd3)
    else $error("blank run count out of range");
  a_bcd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni) bcd_ok)
    else $error("line counter holds a non-BCD digit");
  a_drop_keeps_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (accept_i && suppress) |=> prev_q)
    else $error("dropped blank line changed the newline flag");
`endif

endmodule

/* rtl/tlvf_drain.sv */
// Result buffer: holds one expanded byte as fixed slots and sends them out
// one beat at a time. Depends on tlvf_pkg and tlvf_out_if.
module tlvf_drain import tlvf_pkg::*; #(
  parameter int NumDigits = NUMBER_DIGITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  tlvf_item_t                item_i,
  input  logic [NumDigits-1:0][7:0] digit_chars_i,
  output logic                      in_ready_o,
  tlvf_out_if.source                out_o
);

  // slots: digits, tab, mark, char
  localparam int Slots = NumDigits + 3;
  localparam int IdxW  = $clog2(Slots);
  localparam logic [IdxW-1:0] TabSlot  = IdxW'(NumDigits);
  localparam logic [IdxW-1:0] MarkSlot = IdxW'(NumDigits + 1);
  localparam logic [IdxW-1:0] CharSlot = IdxW'(NumDigits + 2);

  logic [Slots-1:0][7:0] slot_q;
  logic                  mark_v_q;
  logic                  busy_q, busy_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  pop, pop_last;

  assign pop        = busy_q && out_o.ready;
  assign pop_last   = pop && (idx_q == CharSlot);
  assign in_ready_o = !busy_q || pop_last;

  assign out_o.valid    = busy_q;
  assign out_o.out_byte = slot_q[idx_q];
  assign out_o.last     = (idx_q == CharSlot);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop) begin
      if (idx_q == TabSlot) idx_d = mark_v_q ? MarkSlot : CharSlot;
      else idx_d = idx_q + 1'b1;
      if (pop_last) busy_d = 1'b0;
    end
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = item_i.num_v ? '0 : (item_i.mark_v ? MarkSlot : CharSlot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int s = 0; s < NumDigits; s++) slot_q[s] <= digit_chars_i[s];
      slot_q[TabSlot]  <= CH_TAB;
      slot_q[MarkSlot] <= item_i.mark_byte;
      slot_q[CharSlot] <= item_i.char_byte;
      mark_v_q         <= item_i.mark_v;
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
      load_i |-> (!busy_q || pop_last))
    else $error("new byte loaded over an undrained result");
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
      load_i |=> out_o.valid)
    else $error("loaded result not presented");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      busy_q |-> (idx_q <= CharSlot))
    else $error("slot pointer past char slot");
`endif

endmodule

/* rtl/text_line_view_filter_top.sv */
// Text line view filter: line numbering, blank squeezing, caret/end marks.
// Depends on tlvf_pkg, tlvf_in_if, tlvf_out_if, tlvf_line_ctl, tlvf_drain.
// Latency: first result beat is valid the cycle after the input beat.
// Flow: an input producing k result beats (0..NumDigits+3) keeps the buffer busy
// until all k have left; the next input is taken in the cycle the last beat leaves.
// Reset: registers clear, line state is "after newline", counter reads 1.
module text_line_view_filter_top import tlvf_pkg::*; #(
  parameter int NumDigits = NUMBER_DIGITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  tlvf_in_if.sink               in_i,
  tlvf_out_if.source            out_o
);

  tlvf_cfg_t                 cfg_q;
  logic                      accept;
  logic                      load;
  logic                      in_ready;
  tlvf_item_t                item;
  logic [NumDigits-1:0][7:0] digit_chars;

  // config registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (tlvf_cfg_idx_e'(cfg_idx_i))
        CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_wdata_i[0];
        CFG_NUMBER_ALL:       cfg_q.number_all       <= cfg_wdata_i[0];
        CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_wdata_i[0];
        CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_wdata_i[0];
        CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_wdata_i[0];
        CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input ready comes from the result buffer: free, or emptying this cycle
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // line state and expansion; a dropped blank line loads nothing
  tlvf_line_ctl #(.NumDigits(NumDigits)) u_line_ctl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (in_i.data_byte),
    .file_start_i  (in_i.file_start),
    .cfg_i         (cfg_q),
    .load_o        (load),
    .item_o        (item),
    .digit_chars_o (digit_chars)
  );

  // result slots, one beat per cycle out while out_o.ready is high
  tlvf_drain #(.NumDigits(NumDigits)) u_drain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .item_i        (item),
    .digit_chars_i (digit_chars),
    .in_ready_o    (in_ready),
    .out_o         (out_o)
  );

endmodule
